/* rtl/core/fpa_pkg.sv */
// Shared types, constants and rounding helper for the fixed-point atan2 block.
`timescale 1ns / 1ps

package fpa_pkg;

  localparam int unsigned DIV_STAGES     = 8;
  localparam int unsigned BITS_PER_STAGE = 2;

  localparam logic [27:0] POLY_CUBIC  = 28'd2847;
  localparam logic [16:0] POLY_LINEAR = 17'd11039;

  localparam logic [15:0] ANG_ZERO     = 16'd0;
  localparam logic [15:0] ANG_45       = 16'd8192;
  localparam logic [15:0] ANG_90       = 16'd16384;
  localparam logic [15:0] ANG_180      = 16'd32768;
  localparam logic [15:0] ANG_225      = 16'd40960;
  localparam logic [15:0] ANG_270      = 16'd49152;

  localparam logic [14:0] HALF_LSB     = 15'h4000;

  typedef enum logic [1:0] {
    MODE_ADD,
    MODE_SUB,
    MODE_FIXED
  } ang_mode_t;

  typedef struct packed {
    logic      neg;
    ang_mode_t mode;
    logic [15:0] base;
  } fpa_ctl_t;

  // Q15 rounding: nearest, exact half goes down, floor shift.
  function automatic logic signed [16:0] q15_round(input logic signed [31:0] p);
    logic signed [32:0] t;
    t = {p[31], p} + ((p[14:0] == HALF_LSB) ? 33'sd0 : 33'sd16384);
    return t[31:15];
  endfunction

endpackage

/* rtl/core/fpa_if.sv */
// Valid/ready channel interfaces for the vector input and the angle output.
`timescale 1ns / 1ps

interface fpa_vec_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] y_value;
  logic signed [15:0] x_value;

  modport source (output valid, output y_value, output x_value, input ready);
  modport sink   (input valid, input y_value, input x_value, output ready);
endinterface

interface fpa_ang_if;
  logic        valid;
  logic        ready;
  logic [15:0] angle;

  modport source (output valid, output angle, input ready);
  modport sink   (input valid, input angle, output ready);
endinterface

/* rtl/core/fixed_point_atan2_top.sv */
// Top level of the pipelined fixed-point atan2 block.
`timescale 1ns / 1ps

// Fixed-point atan2: angle of a signed 16-bit vector as a 16-bit fraction of
// a full turn (65536 units per turn, 8192 = 45 degrees).
//
// Channels: vec carries (y_value, x_value) in, res carries angle out. A
// transaction completes on a rising edge with valid and ready both high.
// Pipeline: one stage for octant selection, eight stages of a restoring
// divider that retire two quotient bits each, and four stages for the two
// Q15 products and the final offset. The output stage is the register that
// drives res.
// Throughput: one transaction per cycle while res is not stalled, set by the
// fully pipelined divider and multipliers; every stage carries its own valid bit.
// Stall: when res holds a valid angle that is not taken, the whole pipeline
// freezes and vec.ready drops; nothing is dropped or repeated. Bubbles in the
// pipeline advance freely while the output register is empty.
// Reset (rst, synchronous, active high) clears all valid bits; payload
// registers are left as they are.
module fixed_point_atan2_top (
  input  logic            clk,
  input  logic            rst,
  fpa_vec_if.sink         vec,
  fpa_ang_if.source       res
);

  localparam int unsigned NDIV = fpa_pkg::DIV_STAGES;
  localparam int unsigned NBPS = fpa_pkg::BITS_PER_STAGE;

  // Global advance enable: move when the output register is free or drained.
  logic en;
  assign en        = !res.valid || res.ready;
  assign vec.ready = en;

  // ---------------- Stage A: octant selection ----------------
  logic signed [16:0] ys, xs;
  logic [16:0]        mag_y, mag_x;
  logic [16:0]        sel_num, sel_den;
  fpa_pkg::fpa_ctl_t  sel_ctl;

  always_comb begin
    ys    = {vec.y_value[15], vec.y_value};
    xs    = {vec.x_value[15], vec.x_value};
    mag_y = ys[16] ? 17'(-ys) : 17'(ys);
    mag_x = xs[16] ? 17'(-xs) : 17'(xs);
    sel_ctl.neg  = 1'b0;
    sel_ctl.mode = fpa_pkg::MODE_FIXED;
    sel_ctl.base = fpa_pkg::ANG_ZERO;
    sel_num = mag_y;
    sel_den = mag_x;
    if (vec.y_value == vec.x_value) begin
      // Equal components: fixed diagonal angle, divider output unused.
      sel_ctl.mode = fpa_pkg::MODE_FIXED;
      if (vec.y_value[15])
        sel_ctl.base = fpa_pkg::ANG_225;
      else if (vec.y_value != 16'sd0)
        sel_ctl.base = fpa_pkg::ANG_45;
      else
        sel_ctl.base = fpa_pkg::ANG_ZERO;
    end else if (mag_x > mag_y) begin
      // Horizontal dominant: r = y/x, angle = offset + poly.
      sel_num      = mag_y;
      sel_den      = mag_x;
      sel_ctl.neg  = vec.y_value[15] ^ vec.x_value[15];
      sel_ctl.mode = fpa_pkg::MODE_ADD;
      sel_ctl.base = vec.x_value[15] ? fpa_pkg::ANG_180 : fpa_pkg::ANG_ZERO;
    end else begin
      // Vertical dominant or opposite tie: r = x/y, angle = offset - poly.
      sel_num      = mag_x;
      sel_den      = mag_y;
      sel_ctl.neg  = vec.y_value[15] ^ vec.x_value[15];
      sel_ctl.mode = fpa_pkg::MODE_SUB;
      sel_ctl.base = vec.y_value[15] ? fpa_pkg::ANG_270 : fpa_pkg::ANG_90;
    end
  end

  // ---------------- Divider pipeline ----------------
  // Index 0 is the stage A register; 1..NDIV retire NBPS quotient bits each.
  logic [16:0]       dv_rem   [NDIV+1];
  logic [16:0]       dv_den   [NDIV+1];
  logic [15:0]       dv_quo   [NDIV+1];
  fpa_pkg::fpa_ctl_t dv_ctl   [NDIV+1];
  logic              dv_valid [NDIV+1];

  logic [16:0] nx_rem [NDIV];
  logic [15:0] nx_quo [NDIV];

  always_comb begin
    logic [17:0] trial;
    logic [16:0] rem;
    logic [15:0] quo;
    for (int k = 0; k < NDIV; k++) begin
      rem = dv_rem[k];
      quo = dv_quo[k];
      for (int j = 0; j < NBPS; j++) begin
        // The very first quotient bit weighs 2^15 and needs no shift.
        if (k == 0 && j == 0)
          trial = {1'b0, rem};
        else
          trial = {rem, 1'b0};
        if (trial >= {1'b0, dv_den[k]}) begin
          trial = trial - {1'b0, dv_den[k]};
          quo   = {quo[14:0], 1'b1};
        end else begin
          quo   = {quo[14:0], 1'b0};
        end
        rem = trial[16:0];
      end
      nx_rem[k] = rem;
      nx_quo[k] = quo;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_rem[0] <= sel_num;
      dv_den[0] <= sel_den;
      dv_quo[0] <= 16'd0;
      dv_ctl[0] <= sel_ctl;
      for (int k = 0; k < NDIV; k++) begin
        dv_rem[k+1] <= nx_rem[k];
        dv_den[k+1] <= dv_den[k];
        dv_quo[k+1] <= nx_quo[k];
        dv_ctl[k+1] <= dv_ctl[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= NDIV; k++) dv_valid[k] <= 1'b0;
    end else if (en) begin
      dv_valid[0] <= vec.valid;
      for (int k = 0; k < NDIV; k++) dv_valid[k+1] <= dv_valid[k];
    end
  end

  // ---------------- Polynomial stages ----------------
  // M1: signed ratio and 2847*|r|.
  logic [15:0]        q_fin;
  fpa_pkg::fpa_ctl_t  c_fin;
  assign q_fin = dv_quo[NDIV];
  assign c_fin = dv_ctl[NDIV];

  logic signed [16:0] m1_r;
  logic [27:0]        m1_cubic;
  fpa_pkg::fpa_ctl_t  m1_ctl;
  logic               m1_valid;

  // M2: linear coefficient corrected by the cubic term.
  logic signed [31:0] m2_p;
  logic signed [16:0] m2_corr;
  logic signed [16:0] m2_sum;
  logic [13:0]        m2_a;
  logic signed [16:0] m2_r;
  fpa_pkg::fpa_ctl_t  m2_ctl;
  logic               m2_valid;

  // M3: full product a*r.
  logic signed [31:0] m3_p;
  fpa_pkg::fpa_ctl_t  m3_ctl;
  logic               m3_valid;

  // M4: rounding and octant offset.
  logic signed [16:0] m4_u;
  logic [15:0]        m4_angle;
  logic [15:0]        res_angle;
  logic               res_valid;

  always_comb begin
    m2_p    = 32'sd0 - $signed({4'd0, m1_cubic});
    m2_corr = fpa_pkg::q15_round(m2_p);
    m2_sum  = $signed(fpa_pkg::POLY_LINEAR) + m2_corr;
  end

  always_comb begin
    m4_u = fpa_pkg::q15_round(m3_p);
    case (m3_ctl.mode)
      fpa_pkg::MODE_ADD:   m4_angle = m3_ctl.base + m4_u[15:0];
      fpa_pkg::MODE_SUB:   m4_angle = m3_ctl.base - m4_u[15:0];
      fpa_pkg::MODE_FIXED: m4_angle = m3_ctl.base;
      default:             m4_angle = m3_ctl.base;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_r      <= c_fin.neg ? 17'(-$signed({1'b0, q_fin})) : $signed({1'b0, q_fin});
      m1_cubic  <= 28'(q_fin) * fpa_pkg::POLY_CUBIC;
      m1_ctl    <= c_fin;
      m2_a      <= m2_sum[13:0];
      m2_r      <= m1_r;
      m2_ctl    <= m1_ctl;
      m3_p      <= $signed({18'd0, m2_a}) * $signed({{15{m2_r[16]}}, m2_r});
      m3_ctl    <= m2_ctl;
      res_angle <= m4_angle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid  <= 1'b0;
      m2_valid  <= 1'b0;
      m3_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else if (en) begin
      m1_valid  <= dv_valid[NDIV];
      m2_valid  <= m1_valid;
      m3_valid  <= m2_valid;
      res_valid <= m3_valid;
    end
  end

  assign res.valid = res_valid;
  assign res.angle = res_angle;

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the fixed-point atan2 block.
`timescale 1ns / 1ps

module testbench;

  // Pipeline depth given for the block, and the run-time ceiling in cycles.
  localparam int PIPE_LATENCY = 13;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 1425;

  // One expected angle, kept with the vector that produced it for messages.
  typedef struct {
    logic signed [15:0] y;
    logic signed [15:0] x;
    logic [15:0]        angle;
  } angle_entry_t;

  logic clk = 1'b0;
  logic rst;

  fpa_vec_if vec_ch ();
  fpa_ang_if ang_ch ();

  fixed_point_atan2_top i_dut (
    .clk (clk),
    .rst (rst),
    .vec (vec_ch),
    .res (ang_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  angle_entry_t pending_angles[$];
  int           error_count = 0;
  int           cycle_count = 0;
  // When set, both sides run back to back with no idle cycles.
  bit           pace_free   = 1'b0;

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Angle predictor
  // ---------------------------------------------------------------------------

  // Negative magnitude: never overflows, -32768 keeps magnitude 32768.
  function automatic int neg_mag(input int v);
    return (v < 0) ? v : -v;
  endfunction

  // Q15 product, round to nearest with an exact half rounding down, floor shift.
  function automatic int q15_mul(input int a, input int b);
    int     p;
    longint t;
    p = a * b;
    t = longint'(p) + ((p[14:0] == 15'h4000) ? 64'sd0 : 64'sd16384);
    return int'(t >>> 15);
  endfunction

  // Arctangent approximation over one octant: (11039 - 2847*|r|) * r in Q15.
  function automatic int octant_poly(input int r);
    int corr;
    corr = q15_mul(int'(fpa_pkg::POLY_CUBIC), neg_mag(r));
    return q15_mul(int'(fpa_pkg::POLY_LINEAR) + corr, r);
  endfunction

  function automatic logic [15:0] atan2_angle(input logic signed [15:0] y_in,
                                              input logic signed [15:0] x_in);
    int y;
    int x;
    int r;
    int u;
    int a;
    y = y_in;
    x = x_in;
    if (x == y) begin
      // Equal components land on the diagonal, or the origin.
      a = (y > 0) ? int'(fpa_pkg::ANG_45) :
          ((y < 0) ? int'(fpa_pkg::ANG_225) : int'(fpa_pkg::ANG_ZERO));
    end else if (neg_mag(x) < neg_mag(y)) begin
      // Horizontal dominant: ratio y/x, quotient truncated toward zero.
      r = (y * 32768) / x;
      u = octant_poly(r);
      a = (x > 0) ? u : int'(fpa_pkg::ANG_180) + u;
    end else begin
      // Vertical dominant or magnitude tie: ratio x/y.
      r = (x * 32768) / y;
      u = octant_poly(r);
      a = (y > 0) ? int'(fpa_pkg::ANG_90) - u : int'(fpa_pkg::ANG_270) - u;
    end
    return a[15:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Vector source side
  // ---------------------------------------------------------------------------

  function automatic int draw_gap();
    return pace_free ? 0 : int'($urandom_range(0, 12));
  endfunction

  // Offers one vector and returns once the transaction has completed. Valid is
  // left high so a back-to-back vector follows without a bubble.
  task automatic send_vector(input logic signed [15:0] y, input logic signed [15:0] x);
    int           gap;
    angle_entry_t entry;
    gap = draw_gap();
    if (gap > 0) begin
      vec_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    vec_ch.valid   <= 1'b1;
    vec_ch.y_value <= y;
    vec_ch.x_value <= x;
    do @(posedge clk); while (!vec_ch.ready);
    entry.y     = y;
    entry.x     = x;
    entry.angle = atan2_angle(y, x);
    pending_angles.push_back(entry);
  endtask

  // Stops sending and holds off until every outstanding angle has come back.
  task automatic hold_until_drained();
    vec_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_angles.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Angle sink side and checker
  // ---------------------------------------------------------------------------

  initial begin : angle_checker
    int           stall;
    angle_entry_t want;
    ang_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        ang_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      ang_ch.ready <= 1'b1;
      do @(posedge clk); while (!ang_ch.valid);
      if (pending_angles.size() == 0) begin
        $error("angle: no transaction outstanding, actual %0d", ang_ch.angle);
        error_count++;
      end else begin
        want = pending_angles.pop_front();
        if (ang_ch.angle !== want.angle) begin
          $error("angle: expected %0d, actual %0d (y %0d, x %0d)",
                 want.angle, ang_ch.angle, want.y, want.x);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // x equal to y: fixed angles at 45 and 225 degrees and at the origin.
  task automatic test_equal_components();
    send_vector(16'sd0, 16'sd0);
    send_vector(16'sd1, 16'sd1);
    send_vector(16'sd32767, 16'sd32767);
    send_vector(-16'sd1, -16'sd1);
    send_vector(-16'sd32768, -16'sd32768);
  endtask

  // Axes, the most negative value, and the anti-diagonal where r is -1.0.
  task automatic test_axes_and_extremes();
    send_vector(16'sd0, 16'sd32767);
    send_vector(16'sd0, -16'sd32768);
    send_vector(16'sd32767, 16'sd0);
    send_vector(-16'sd32768, 16'sd0);
    send_vector(-16'sd32768, 16'sd32767);
    send_vector(16'sd32767, -16'sd32768);
    send_vector(-16'sd32768, -16'sd32767);
    send_vector(-16'sd32768, 16'sd1);
    send_vector(16'sd5, -16'sd5);
    send_vector(-16'sd32767, 16'sd32767);
  endtask

  // One vector in each octant, plus near-ties on both sides of the diagonal.
  task automatic test_octants();
    send_vector(16'sd1000, 16'sd3000);
    send_vector(16'sd3000, 16'sd1000);
    send_vector(16'sd3000, -16'sd1000);
    send_vector(16'sd1000, -16'sd3000);
    send_vector(-16'sd1000, -16'sd3000);
    send_vector(-16'sd3000, -16'sd1000);
    send_vector(-16'sd3000, 16'sd1000);
    send_vector(-16'sd1000, 16'sd3000);
    send_vector(16'sd100, 16'sd101);
    send_vector(16'sd101, 16'sd100);
  endtask

  function automatic logic [15:0] pick_edge_value();
    case ($urandom_range(0, 6))
      0:       return 16'h8000;
      1:       return 16'h8001;
      2:       return 16'hFFFF;
      3:       return 16'h0000;
      4:       return 16'h0001;
      5:       return 16'h7FFF;
      default: return 16'($urandom());
    endcase
  endfunction

  // Mixed random vectors: half uniform, the rest near-diagonal, tiny and edge
  // values that steer into ties, small ratios and the rounding corners.
  task automatic test_random_vectors();
    int                 a;
    int                 b;
    int                 kind;
    logic signed [15:0] y;
    logic signed [15:0] x;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // Stretches with and without idle cycles on both sides, chosen at random.
      if (i % 150 == 0) pace_free = ($urandom_range(0, 2) == 0);
      // Sender holds off once mid-run until the pipeline has emptied.
      if (i == RANDOM_ITEMS / 2) hold_until_drained();
      kind = $urandom_range(0, 9);
      if (kind <= 4) begin
        y = 16'($urandom());
        x = 16'($urandom());
      end else if (kind <= 6) begin
        a = int'($urandom_range(0, 65535)) - 32768;
        b = ($urandom_range(0, 1) ? a : -a) + int'($urandom_range(0, 6)) - 3;
        y = a[15:0];
        x = b[15:0];
      end else if (kind <= 8) begin
        a = int'($urandom_range(0, 16)) - 8;
        b = int'($urandom_range(0, 16)) - 8;
        y = a[15:0];
        x = b[15:0];
      end else begin
        y = pick_edge_value();
        x = pick_edge_value();
      end
      send_vector(y, x);
    end
    pace_free = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst            = 1'b1;
    vec_ch.valid   = 1'b0;
    vec_ch.y_value = '0;
    vec_ch.x_value = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_equal_components();
    test_axes_and_extremes();
    test_octants();
    hold_until_drained();
    test_random_vectors();
    hold_until_drained();

    // Any stray angle after the last one shows up in the checker here.
    repeat (3 * PIPE_LATENCY) @(posedge clk);
    if (pending_angles.size() != 0) begin
      $error("angle: %0d transactions never returned", pending_angles.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
